>>> design/lto_pkg.sv
// Shared package for the lexicographic topological order block.
// Holds the default node count, field widths, word actions and the cell control word.
// Used by lto_cell, lexicographic_topological_order_top and the testbench; depends on nothing.
`timescale 1ns / 1ps

package lto_pkg;

    // Default number of node cells in the chain.
    localparam int NODES_DEF = 32;

    // Width of a node index field on the ports.
    localparam int IDX_W = 5;

    // Actions carried by an input word.
    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    // Control word broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             load;   // load one dependency edge
        logic             clear;  // wipe the whole graph
        logic             step;   // mark the granted cell as emitted
        logic [IDX_W-1:0] pre;    // prerequisite node of the edge
        logic [IDX_W-1:0] dep;    // dependent node of the edge
    } cell_ctl_t;

endpackage

>>> design/lexicographic_topological_order_top.sv
// Top level of the lexicographic topological order block.
// Holds the sequencer, the output register and a chain of lto_cell instances.
// Depends on lto_pkg and lto_cell.
`timescale 1ns / 1ps

// An edge word (action 0) is taken while no run is in progress, and edge words may follow
// one another in every cycle. A run word (action 1) starts a run that emits each present
// node that can be ordered, then the closing word; stalls on the output hold the run. The
// order is set by the grant token that ripples once per cycle through the row of node
// cells, each cycle granting the lowest ready node, and by the single output register.
// No new word is taken until the closing word of a run has been loaded. The closing word
// carries last = 1 and cycle_found = 1 when present nodes were left unemitted; after it
// the graph is empty.
module lexicographic_topological_order_top #(
    parameter int NODES = lto_pkg::NODES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    action,
    input  logic [lto_pkg::IDX_W-1:0] prereq_node,
    input  logic [lto_pkg::IDX_W-1:0] dependent_node,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [lto_pkg::IDX_W-1:0] node_index,
    output logic                    node_valid,
    output logic                    cycle_found,
    output logic                    last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [lto_pkg::IDX_W-1:0] node_index_reg;
    logic [lto_pkg::IDX_W-1:0] node_index_next;
    logic                      node_valid_reg;
    logic                      node_valid_next;
    logic                      cycle_found_reg;
    logic                      cycle_found_next;
    logic                      last_reg;
    logic                      last_next;

    logic                      in_take;
    logic                      edge_ok;
    logic                      slot_free;
    logic                      any_ready;
    logic                      emit;
    logic                      finish;
    logic [lto_pkg::IDX_W-1:0] pick_idx;
    lto_pkg::cell_ctl_t        ctl;

    logic [NODES:0]            chain;
    logic [NODES-1:0]          grant_vec;
    logic [NODES-1:0]          done_vec;
    logic [NODES-1:0]          present_vec;
    logic [NODES-1:0]          pending_vec;

    // Handshake on both sides.
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign node_index  = node_index_reg;
    assign node_valid  = node_valid_reg;
    assign cycle_found = cycle_found_reg;
    assign last        = last_reg;

    // An edge naming a node beyond the chain is dropped.
    assign edge_ok = (32'(prereq_node) < 32'(NODES)) && (32'(dependent_node) < 32'(NODES));

    // Emit a node when one is ready, otherwise close the run.
    assign any_ready = !chain[NODES];
    assign emit      = (state_reg == ST_RUN) && slot_free && any_ready;
    assign finish    = (state_reg == ST_RUN) && slot_free && !any_ready;

    always_comb
    begin
        ctl.load  = in_take && (action == lto_pkg::ACT_EDGE) && edge_ok;
        ctl.clear = finish;
        ctl.step  = emit;
        ctl.pre   = prereq_node;
        ctl.dep   = dependent_node;
    end

    // Chain of node cells; the token enters at the lowest index.
    assign chain[0] = 1'b1;

    for (genvar i = 0; i < NODES; i++)
    begin : g_cell
        lto_cell #(
            .NODES (NODES),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .done_vec  (done_vec),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .grant     (grant_vec[i]),
            .done      (done_vec[i]),
            .present   (present_vec[i]),
            .pending   (pending_vec[i])
        );
    end

    // Encode the granted cell; at most one cell holds the grant.
    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < NODES; i++)
        begin
            if (grant_vec[i])
            begin
                pick_idx = pick_idx | lto_pkg::IDX_W'(i);
            end
        end
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        node_index_next  = node_index_reg;
        node_valid_next  = node_valid_reg;
        cycle_found_next = cycle_found_reg;
        last_next        = last_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (action == lto_pkg::ACT_RUN))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next   = 1'b1;
                    node_index_next  = pick_idx;
                    node_valid_next  = 1'b1;
                    cycle_found_next = 1'b0;
                    last_next        = 1'b0;
                end
                else if (finish)
                begin
                    out_valid_next   = 1'b1;
                    node_index_next  = '0;
                    node_valid_next  = 1'b0;
                    cycle_found_next = |pending_vec;
                    last_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_index_reg  <= node_index_next;
        node_valid_reg  <= node_valid_next;
        cycle_found_reg <= cycle_found_next;
        last_reg        <= last_next;
    end

    // The token chain never grants two cells at once.
    a_single_grant: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(grant_vec))
        else $error("more than one node cell granted");

    // Once the closing word is loaded, the graph is empty and the sequencer idle.
    a_cleared_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (present_vec == '0 && state_reg == ST_IDLE))
        else $error("graph not cleared after the closing word");

    // An accepted run word starts the emission sequence.
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (action == lto_pkg::ACT_RUN)) |=> (state_reg == ST_RUN))
        else $error("run word did not start a run");

endmodule

>>> design/lto_cell.sv
// One node cell of the ordering chain: present bit, emitted bit, prerequisite row.
// Passes the "no lower node ready" token to its upper neighbour every cycle.
// Depends on lto_pkg.
`timescale 1ns / 1ps

module lto_cell #(
    parameter int NODES = lto_pkg::NODES_DEF,
    parameter int IDX   = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lto_pkg::cell_ctl_t ctl,
    input  logic [NODES-1:0]   done_vec,
    input  logic               chain_in,
    output logic               chain_out,
    output logic               grant,
    output logic               done,
    output logic               present,
    output logic               pending
);

    logic             present_reg;
    logic             present_next;
    logic             done_reg;
    logic             done_next;
    logic [NODES-1:0] needs_reg;
    logic [NODES-1:0] needs_next;
    logic [NODES-1:0] pre_onehot;
    logic             hit_pre;
    logic             hit_dep;
    logic             ready;

    // Decode the edge against this cell's own index.
    assign hit_pre = (32'(ctl.pre) == 32'(IDX));
    assign hit_dep = (32'(ctl.dep) == 32'(IDX));

    always_comb
    begin
        for (int j = 0; j < NODES; j++)
        begin
            pre_onehot[j] = (32'(ctl.pre) == 32'(j));
        end
    end

    // A node is ready when present, not yet emitted, and all prerequisites are emitted.
    assign ready     = present_reg && !done_reg && ((needs_reg & ~done_vec) == '0);
    assign grant     = chain_in && ready;
    assign chain_out = chain_in && !ready;
    assign done      = done_reg;
    assign present   = present_reg;
    assign pending   = present_reg && !done_reg;

    // Next state of the cell.
    always_comb
    begin
        present_next = present_reg;
        needs_next   = needs_reg;
        done_next    = done_reg;
        if (ctl.clear)
        begin
            present_next = 1'b0;
            needs_next   = '0;
            done_next    = 1'b0;
        end
        else
        begin
            if (ctl.load && (hit_pre || hit_dep))
            begin
                present_next = 1'b1;
            end
            if (ctl.load && hit_dep)
            begin
                needs_next = needs_reg | pre_onehot;
            end
            if (ctl.step && grant)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            needs_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            needs_reg   <= needs_next;
            done_reg    <= done_next;
        end
    end

endmodule

>>> tb/sv/lexicographic_topological_order_top_test.sv
// Self-checking testbench for lexicographic_topological_order_top.
// Loads dependency graphs word by word and checks every emitted node and closing word.
// Depends on lto_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module lexicographic_topological_order_top_test;

    localparam int NODES = lto_pkg::NODES_DEF;
    localparam int IDX_W = lto_pkg::IDX_W;

    // Input word actions.
    localparam logic ACT_EDGE = lto_pkg::ACT_EDGE;
    localparam logic ACT_RUN  = lto_pkg::ACT_RUN;

    localparam int RANDOM_WORDS = 250;
    localparam int CALM_TAIL    = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PRINT_CAP    = 100;

    typedef struct packed {
        logic             act;
        logic [IDX_W-1:0] pre;
        logic [IDX_W-1:0] dep;
    } graph_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             carried;
        logic             cyc;
        logic             closing;
    } order_entry_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             action = ACT_EDGE;
    logic [IDX_W-1:0] prereq_node = '0;
    logic [IDX_W-1:0] dependent_node = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [IDX_W-1:0] node_index;
    logic             node_valid;
    logic             cycle_found;
    logic             last;

    lexicographic_topological_order_top #(
        .NODES(NODES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .prereq_node(prereq_node),
        .dependent_node(dependent_node),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .node_index(node_index),
        .node_valid(node_valid),
        .cycle_found(cycle_found),
        .last(last)
    );

    // Mirror of the graph held by the block.
    logic [NODES-1:0] needs_rows [NODES];
    logic [NODES-1:0] present_nodes = '0;

    graph_word_t  pending_words[$];
    order_entry_t predicted_order[$];

    int unsigned mismatches = 0;
    int unsigned words_taken = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    bit          calm = 1'b0;
    bit          long_hold = 1'b0;
    graph_word_t next_word;
    graph_word_t taken_word;
    order_entry_t seen;
    order_entry_t want;

    // Stimulus construction state.
    int perm [NODES];
    int rank [NODES];
    int last_pre;
    int last_dep;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("lexicographic_topological_order_top test failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Append one word to the stimulus queue.
    task automatic queue_word(input graph_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    // Append one predicted result word.
    task automatic queue_result(input order_entry_t e);
        predicted_order.insert(predicted_order.size(), e);
    endtask

    // Apply one accepted word to the graph mirror and queue the nodes it emits.
    task automatic advance_graph(input graph_word_t w);
        logic [NODES-1:0] emitted;
        int               pick;
        order_entry_t     e;
        if (w.act == ACT_EDGE)
        begin
            if (int'(w.pre) < NODES && int'(w.dep) < NODES)
            begin
                present_nodes[w.pre] = 1'b1;
                present_nodes[w.dep] = 1'b1;
                needs_rows[w.dep][w.pre] = 1'b1;
            end
        end
        else
        begin
            emitted = '0;
            do
            begin
                pick = NODES;
                for (int i = 0; i < NODES; i++)
                begin
                    if (present_nodes[i] && !emitted[i] && (needs_rows[i] & ~emitted) == '0)
                    begin
                        pick = i;
                        break;
                    end
                end
                if (pick < NODES)
                begin
                    emitted[pick] = 1'b1;
                    e = '{node: pick[IDX_W-1:0], carried: 1'b1, cyc: 1'b0, closing: 1'b0};
                    queue_result(e);
                end
            end
            while (pick < NODES);
            e = '{node: '0, carried: 1'b0, cyc: ((present_nodes & ~emitted) != '0),
                  closing: 1'b1};
            queue_result(e);
            present_nodes = '0;
            for (int i = 0; i < NODES; i++)
                needs_rows[i] = '0;
        end
    endtask

    task automatic add_edge(input int pre, input int dep);
        graph_word_t w;
        w = '{act: ACT_EDGE, pre: pre[IDX_W-1:0], dep: dep[IDX_W-1:0]};
        queue_word(w);
        last_pre = pre;
        last_dep = dep;
    endtask

    // Node fields of a run word are don't-care, so they carry random values.
    task automatic add_run();
        graph_word_t w;
        w = '{act: ACT_RUN, pre: IDX_W'($urandom), dep: IDX_W'($urandom)};
        queue_word(w);
    endtask

    task automatic shuffle_nodes();
        int j;
        int t;
        for (int i = 0; i < NODES; i++)
            perm[i] = i;
        for (int i = NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int i = 0; i < NODES; i++)
            rank[perm[i]] = i;
    endtask

    // Input side: present queued words, with random bursts of idle cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= ACT_EDGE;
            prereq_node <= '0;
            dependent_node <= '0;
            calm <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            calm <= (pending_words.size() < CALM_TAIL);
            if (in_valid && !in_stall)
            begin
                taken_word = {action, prereq_node, dependent_node};
                advance_graph(taken_word);
                words_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    action <= next_word.act;
                    prereq_node <= next_word.pre;
                    dependent_node <= next_word.dep;
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 16);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: check each accepted word and stall in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{node: node_index, carried: node_valid, cyc: cycle_found, closing: last};
                if (predicted_order.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected word node %0d valid %0b cycle %0b last %0b",
                                            seen.node, seen.carried, seen.cyc, seen.closing));
                end
                else
                begin
                    want = predicted_order.pop_front();
                    if (seen.node !== want.node)
                        flag_mismatch($sformatf("node_index %0d, expected %0d",
                                                seen.node, want.node));
                    if (seen.carried !== want.carried)
                        flag_mismatch($sformatf("node_valid %0b, expected %0b",
                                                seen.carried, want.carried));
                    if (seen.cyc !== want.cyc)
                        flag_mismatch($sformatf("cycle_found %0b, expected %0b",
                                                seen.cyc, want.cyc));
                    if (seen.closing !== want.closing)
                        flag_mismatch($sformatf("last %0b, expected %0b",
                                                seen.closing, want.closing));
                end
            end
            if (long_hold)
            begin
                out_stall <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so that a run backs up and the input stalls.
    initial
    begin
        do @(negedge clk); while (words_taken < 60);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Build the stimulus, release reset and wait for the last word to drain.
    initial
    begin
        int n_edges;
        int kind;
        int a;
        int b;
        int t;
        int lo;
        int target;
        graph_word_t w;

        for (int i = 0; i < NODES; i++)
            needs_rows[i] = '0;

        // Empty graph: only the closing word, with no cycle.
        add_run();
        // Extreme indices in a chain.
        add_edge(0, 31);
        add_edge(31, 5);
        add_run();
        // A self edge is never ready and counts as a cycle.
        add_edge(7, 7);
        add_edge(3, 4);
        add_run();
        // Repeated edge, then a two-node cycle beside an orderable pair.
        add_edge(2, 9);
        add_edge(2, 9);
        add_edge(9, 2);
        add_edge(1, 30);
        add_run();
        // Several ready nodes at once: the lowest index goes first.
        add_edge(10, 20);
        add_edge(5, 20);
        add_edge(12, 13);
        add_run();
        // Run with both node fields at their maximum on an empty graph.
        w = '{act: ACT_RUN, pre: '1, dep: '1};
        queue_word(w);

        target = pending_words.size() + RANDOM_WORDS;
        while (pending_words.size() < target)
        begin
            shuffle_nodes();
            kind = $urandom_range(0, 15);
            if (kind == 0)
            begin
                // Every node in one random chain: the longest run.
                for (int i = 0; i < NODES - 1; i++)
                    add_edge(perm[i], perm[i + 1]);
            end
            else
            begin
                n_edges = $urandom_range(0, 8);
                lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, NODES - 8);
                for (int k = 0; k < n_edges; k++)
                begin
                    if (lo == 0)
                    begin
                        a = $urandom_range(0, NODES - 1);
                        b = $urandom_range(0, NODES - 1);
                    end
                    else
                    begin
                        a = lo + $urandom_range(0, 7);
                        b = lo + $urandom_range(0, 7);
                    end
                    if (kind <= 13)
                    begin
                        // Acyclic: orient every edge along a random ranking.
                        if (a == b)
                            b = a ^ 1;
                        if (rank[a] > rank[b])
                        begin
                            t = a;
                            a = b;
                            b = t;
                        end
                    end
                    add_edge(a, b);
                end
                // Broken sequences close a cycle with a back edge or a self edge.
                if (kind >= 12 && kind <= 13)
                begin
                    if (n_edges != 0 && $urandom_range(0, 1))
                        add_edge(last_dep, last_pre);
                    else
                    begin
                        a = $urandom_range(0, NODES - 1);
                        add_edge(a, a);
                    end
                end
            end
            add_run();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk); while (pending_words.size() != 0 || in_valid);
        do @(negedge clk); while (predicted_order.size() != 0);
        repeat (40) @(negedge clk);

        if (mismatches == 0)
            $display("lexicographic_topological_order_top test passed");
        else
            $display("lexicographic_topological_order_top test failed");
        $finish;
    end

endmodule

>>> lexicographic_topological_order_top.f
design/lto_pkg.sv
design/lto_cell.sv
design/lexicographic_topological_order_top.sv
tb/sv/lexicographic_topological_order_top_test.sv
